@@ rtl/sitd_pkg.sv @@
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared types, constants and tables for the signed integer to decimal
// text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitd_pkg;

  localparam int VALUE_W      = 32;
  localparam int CHAR_W       = 6;
  localparam int IDX_W        = 4;
  localparam int WIDE_W       = 34;  // holds 9 * 10^9
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 6'd45;
  localparam logic [CHAR_W-1:0] ZERO_CODE  = 6'd48;
  localparam logic [IDX_W-1:0]  TOP_IDX    = 4'd9;   // 10^9 place
  localparam logic [IDX_W-1:0]  MAX_DIGIT  = 4'd9;

  // Sign and magnitude of one value, as queued between front and back.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SIGN,
    B_DIGIT
  } back_state_t;

  // Power of ten for a decimal place.
  function automatic logic [WIDE_W-1:0] pow10(input logic [IDX_W-1:0] idx);
    logic [WIDE_W-1:0] p;
    unique case (idx)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sitd_if.sv @@
// ----------------------------------------------------------------------------
// sitd_if
// Valid/ready channels of the converter: the integer input channel and the
// character output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sitd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sitd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_out_if;
  logic                        valid;
  logic                        ready;
  logic [sitd_pkg::CHAR_W-1:0] character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, one character per output
// transaction, most significant first, minus sign for negative values.
// ----------------------------------------------------------------------------
// Order: the front registers the value, the queue holds it, and the back
//   walks its decimal places from 10^9 down, one place per cycle while the
//   output does not stall, after the sign for a negative value; leading zero
//   places emit no character. The back takes the next value from the queue
//   on the final decimal place of the previous one.
// Reset (rst, synchronous): empties the front register, the queue and the
//   output register and returns the back to idle; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_core #(
  parameter int QUEUE_DEPTH = sitd_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  sitd_in_if.sink   in,
  sitd_out_if.source out
);

  // Front to queue: one classified value (sign plus magnitude) per
  // transaction.
  logic             push_valid;
  logic             push_ready;
  sitd_pkg::entry_t push_data;

  // Queue to back: the back pops a value only when it starts converting it,
  // either from idle or on the final decimal place of the previous value.
  logic             q_valid;
  logic             q_ready;
  sitd_pkg::entry_t q_data;

  // Front: take the value, negate negatives into a 32-bit unsigned
  // magnitude, hold it until the queue has room.
  sitd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in         (in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue: decouple input transactions from the character stream so a
  // stalled output does not hold the input side until the queue is full.
  sitd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Back: sign, then one digit per place; leading zeros are dropped, the
  // units digit always goes out and carries the last flag.
  sitd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .out     (out)
  );

endmodule

`default_nettype wire

@@ rtl/sitd_front.sv @@
// ----------------------------------------------------------------------------
// sitd_front
// Accept values, split them into sign and magnitude and register the result
// for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sitd_front (
  input  wire logic         clk,
  input  wire logic         rst,
  sitd_in_if.sink           in,
  output logic              push_valid,
  input  wire logic         push_ready,
  output sitd_pkg::entry_t  push_data
);

  logic             f_valid;
  sitd_pkg::entry_t f_entry;
  sitd_pkg::entry_t classified;
  logic             accept;

  assign in.ready   = !f_valid || push_ready;
  assign accept     = in.valid && in.ready;
  assign push_valid = f_valid;
  assign push_data  = f_entry;

  // Most negative value negates to 2^31, which is exactly right unsigned.
  always_comb begin
    classified.neg = in.value[sitd_pkg::VALUE_W-1];
    classified.mag = classified.neg ? (~in.value + 1'b1) : in.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry <= classified;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sitd_fifo.sv @@
// ----------------------------------------------------------------------------
// sitd_fifo
// Short queue of classified values between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sitd_fifo #(
  parameter int DEPTH = sitd_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire sitd_pkg::entry_t  push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output sitd_pkg::entry_t       pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sitd_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count exceeds depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |=> !(($past(count) == '0) && (count > CNT_W'(1))))
    else $error("queue grew by more than one entry from empty");

endmodule

`default_nettype wire

@@ rtl/sitd_back.sv @@
// ----------------------------------------------------------------------------
// sitd_back
// Emit the sign and the decimal digits of one magnitude, one place per cycle
// from 10^9 down unless the output stalls, with leading zeros dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sitd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire sitd_pkg::entry_t  q_data,
  sitd_out_if.source             out
);

  localparam int W  = sitd_pkg::WIDE_W;
  localparam int VW = sitd_pkg::VALUE_W;
  localparam int DW = sitd_pkg::IDX_W;

  sitd_pkg::back_state_t state;
  sitd_pkg::back_state_t state_next;

  logic [VW-1:0]              mag;
  logic [DW-1:0]              idx;
  logic                       started;
  logic                       out_valid;
  logic [sitd_pkg::CHAR_W-1:0] out_char;
  logic                       out_last;

  logic [W-1:0]  pow;
  logic [W-1:0]  mult [10];
  logic [8:0]    ge;
  logic [DW-1:0] digit;
  logic [W-1:0]  sub;
  logic          emit;
  logic          can_load;
  logic          step;
  logic          last_step;
  logic          take;
  logic          load_sign;
  logic          load_digit;

  assign out.valid     = out_valid;
  assign out.character = out_char;
  assign out.last      = out_last;
  assign can_load      = !out_valid || out.ready;

  // Digit of the current place: how many multiples of 10^idx fit.
  always_comb begin
    pow = sitd_pkg::pow10(idx);
    for (int k = 0; k < 10; k++) begin
      mult[k] = pow * W'(k);
    end
    for (int k = 1; k < 10; k++) begin
      ge[k-1] = ({{(W-VW){1'b0}}, mag} >= mult[k]);
    end
    digit = DW'($countones(ge));
    sub   = mult[digit];
    emit  = started || (digit != '0) || (idx == '0);
  end

  always_comb begin
    step       = (state == sitd_pkg::B_DIGIT) && (!emit || can_load);
    last_step  = step && (idx == '0);
    take       = q_valid && ((state == sitd_pkg::B_IDLE) || last_step);
    load_sign  = (state == sitd_pkg::B_SIGN) && can_load;
    load_digit = step && emit;
    q_ready    = take;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sitd_pkg::B_IDLE: begin
        if (q_valid) begin
          state_next = q_data.neg ? sitd_pkg::B_SIGN : sitd_pkg::B_DIGIT;
        end
      end
      sitd_pkg::B_SIGN: begin
        if (can_load) begin
          state_next = sitd_pkg::B_DIGIT;
        end
      end
      sitd_pkg::B_DIGIT: begin
        if (last_step) begin
          if (q_valid) begin
            state_next = q_data.neg ? sitd_pkg::B_SIGN : sitd_pkg::B_DIGIT;
          end else begin
            state_next = sitd_pkg::B_IDLE;
          end
        end
      end
      default: state_next = sitd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sitd_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_sign || load_digit) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag     <= q_data.mag;
      idx     <= sitd_pkg::TOP_IDX;
      started <= 1'b0;
    end else if (step) begin
      mag     <= mag - sub[VW-1:0];
      idx     <= idx - 1'b1;
      started <= started || emit;
    end
    if (load_sign) begin
      out_char <= sitd_pkg::MINUS_CODE;
      out_last <= 1'b0;
    end else if (load_digit) begin
      out_char <= sitd_pkg::ZERO_CODE + {{(sitd_pkg::CHAR_W-DW){1'b0}}, digit};
      out_last <= (idx == '0);
    end
  end

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_char == sitd_pkg::MINUS_CODE) ||
                   ((out_char >= sitd_pkg::ZERO_CODE) &&
                    (out_char <= sitd_pkg::ZERO_CODE + 6'd9))))
    else $error("output code is neither minus nor a digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_char == sitd_pkg::MINUS_CODE)) |-> !out_last)
    else $error("minus sign flagged as last character");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == sitd_pkg::B_DIGIT) |-> (digit <= sitd_pkg::MAX_DIGIT))
    else $error("remainder too large for the current place");

  a_top_digit: assert property (@(posedge clk) disable iff (rst)
    ((state == sitd_pkg::B_DIGIT) && (idx == sitd_pkg::TOP_IDX)) |-> (digit <= 4'd4))
    else $error("billions digit out of range for 32 bits");

endmodule

`default_nettype wire
